[hw/rtl/bdq_pkg.sv]
package bdq_pkg;

  // Field widths of one transaction
  localparam int unsigned OpW   = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned StatW = 2;
  localparam int unsigned PosW  = 5;
  localparam int unsigned TotW  = 5;

  // Operation codes
  localparam logic [OpW-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OpW-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OpW-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OpW-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OpW-1:0] OP_SEARCH     = 3'd4;

  // Result status codes
  localparam logic [StatW-1:0] STAT_OK    = 2'd0;
  localparam logic [StatW-1:0] STAT_FULL  = 2'd1;
  localparam logic [StatW-1:0] STAT_EMPTY = 2'd2;

endpackage

[hw/rtl/bounded_deque_with_search.sv]
// Sequence: a push, an unknown opcode, an empty pop and a search of an empty deque go
//   from accept straight to ST_DONE; other pops pass ST_POP first, and a search walks
//   in ST_SRCH until a match or its last live entry. ST_DONE loads the output register.
// Throughput: one transaction at a time; the search walk reads the entry memory
//   one entry per cycle through its single registered read port.
// Reset: rst_ni clears count, front pointer, sum and handshake state at once;
//   the entry memory is not cleared, and only live entries are ever read.
module bounded_deque_with_search
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [OpW-1:0]          opcode_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [StatW-1:0]        status_o,
  output logic                    found_o,
  output logic [PosW-1:0]         position_o,
  output logic signed [DataW-1:0] popped_value_o,
  output logic [TotW-1:0]         entry_total_o,
  output logic signed [DataW-1:0] element_sum_o
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned SW = CW + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SRCH,
    ST_DONE
  } state_e;

  state_e            state_q;
  logic [IW-1:0]     front_q;
  logic [CW-1:0]     count_q;
  logic [DataW-1:0]  sum_q;
  logic [DataW-1:0]  key_q;
  logic [CW-1:0]     idx_q;
  logic              cmp_valid_q;
  logic [CW-1:0]     cmp_off_q;
  logic [StatW-1:0]  res_status_q;
  logic              res_found_q;
  logic [PosW-1:0]   res_pos_q;
  logic [DataW-1:0]  res_pop_q;
  logic              out_valid_q;
  logic [StatW-1:0]  out_status_q;
  logic              out_found_q;
  logic [PosW-1:0]   out_pos_q;
  logic [DataW-1:0]  out_pop_q;
  logic [TotW-1:0]   out_total_q;
  logic [DataW-1:0]  out_sum_q;

  logic [DataW-1:0]  entry_mem_q [DEPTH];
  logic [DataW-1:0]  rdata_q;

  logic              accept;
  logic              is_push;
  logic              is_pop;
  logic              full;
  logic              empty;
  logic [CW-1:0]     slot_off;
  logic [IW-1:0]     slot_d;
  logic [IW-1:0]     front_dec;
  logic [IW-1:0]     front_inc;
  logic              mem_we;
  logic              mem_re;
  logic [IW-1:0]     wr_addr;
  logic [CW:0]       match_pos;

  // Ring slot of an offset from the front; sum stays below 2*DEPTH for every slot that reaches the memory
  function automatic logic [IW-1:0] ring_slot(input logic [IW-1:0] base,
                                              input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  // Handshake and decode
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_push    = (opcode_i == OP_PUSH_FRONT) || (opcode_i == OP_PUSH_BACK);
  assign is_pop     = (opcode_i == OP_POP_FRONT) || (opcode_i == OP_POP_BACK);
  assign full       = (count_q == CW'(DEPTH));
  assign empty      = (count_q == '0);

  // Address generation
  always_comb begin
    priority if (state_q == ST_SRCH) begin
      slot_off = idx_q;
    end else if (opcode_i == OP_PUSH_BACK) begin
      slot_off = count_q;
    end else if (opcode_i == OP_POP_BACK) begin
      slot_off = count_q - CW'(1);
    end else begin
      slot_off = '0;
    end
  end

  assign slot_d    = ring_slot(front_q, slot_off);
  assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
  assign front_inc = ring_slot(front_q, CW'(1));

  // Memory strobes; one transaction at a time keeps a write and a later read apart
  assign mem_we  = accept && is_push && !full;
  assign wr_addr = (opcode_i == OP_PUSH_FRONT) ? front_dec : slot_d;
  assign mem_re  = (accept && is_pop && !empty) ||
                   ((state_q == ST_SRCH) && (idx_q < count_q));

  assign match_pos = {1'b0, cmp_off_q} + (CW + 1)'(1);

  // Entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      entry_mem_q[wr_addr] <= value_i;
    end
    if (mem_re) begin
      rdata_q <= entry_mem_q[slot_d];
    end
  end

  // Sequencer, queue state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      front_q      <= '0;
      count_q      <= '0;
      sum_q        <= '0;
      key_q        <= '0;
      idx_q        <= '0;
      cmp_valid_q  <= 1'b0;
      cmp_off_q    <= '0;
      res_status_q <= STAT_OK;
      res_found_q  <= 1'b0;
      res_pos_q    <= '0;
      res_pop_q    <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STAT_OK;
      out_found_q  <= 1'b0;
      out_pos_q    <= '0;
      out_pop_q    <= '0;
      out_total_q  <= '0;
      out_sum_q    <= '0;
    end else begin
      // The completion state reloads the output register itself
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            res_found_q <= 1'b0;
            res_pos_q   <= '0;
            res_pop_q   <= '0;
            if (is_push) begin
              state_q <= ST_DONE;
              if (full) begin
                res_status_q <= STAT_FULL;
              end else begin
                res_status_q <= STAT_OK;
                if (opcode_i == OP_PUSH_FRONT) begin
                  front_q <= front_dec;
                end
                count_q <= count_q + CW'(1);
                sum_q   <= sum_q + value_i;
              end
            end else if (is_pop) begin
              if (empty) begin
                res_status_q <= STAT_EMPTY;
                state_q      <= ST_DONE;
              end else begin
                res_status_q <= STAT_OK;
                if (opcode_i == OP_POP_FRONT) begin
                  front_q <= front_inc;
                end
                count_q <= count_q - CW'(1);
                state_q <= ST_POP;
              end
            end else if (opcode_i == OP_SEARCH) begin
              res_status_q <= STAT_OK;
              key_q        <= value_i;
              idx_q        <= '0;
              cmp_valid_q  <= 1'b0;
              state_q      <= empty ? ST_DONE : ST_SRCH;
            end else begin
              res_status_q <= STAT_OK;
              state_q      <= ST_DONE;
            end
          end
        end

        // Read data of the popped entry is back
        ST_POP: begin
          res_pop_q <= rdata_q;
          sum_q     <= sum_q - rdata_q;
          state_q   <= ST_DONE;
        end

        // Pipelined walk: issue offset idx_q, compare the previous read
        ST_SRCH: begin
          if (mem_re) begin
            idx_q <= idx_q + CW'(1);
          end
          cmp_off_q <= idx_q;
          if (cmp_valid_q && (rdata_q == key_q)) begin
            res_found_q <= 1'b1;
            res_pos_q   <= PosW'(match_pos);
            cmp_valid_q <= 1'b0;
            state_q     <= ST_DONE;
          end else if (cmp_valid_q && (cmp_off_q == count_q - CW'(1))) begin
            cmp_valid_q <= 1'b0;
            state_q     <= ST_DONE;
          end else begin
            cmp_valid_q <= mem_re;
          end
        end

        // Hand the result to the output register once it is free
        ST_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_found_q  <= res_found_q;
            out_pos_q    <= res_pos_q;
            out_pop_q    <= res_pop_q;
            out_total_q  <= TotW'(count_q);
            out_sum_q    <= sum_q;
            state_q      <= ST_IDLE;
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign found_o        = out_found_q;
  assign position_o     = out_pos_q;
  assign popped_value_o = out_pop_q;
  assign entry_total_o  = out_total_q;
  assign element_sum_o  = out_sum_q;

`ifndef SYNTHESIS
  // Occupancy never exceeds capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above capacity");

  // Front pointer stays inside the ring
  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SW'(front_q) < SW'(DEPTH))
    else $error("front pointer outside ring");

  // A rejected push only happens on a full queue, which it leaves full
  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) && (res_status_q == STAT_FULL) |-> count_q == CW'(DEPTH))
    else $error("full status with free entries");

  // The search only compares live entries
  a_search_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SRCH) && cmp_valid_q |-> cmp_off_q < count_q)
    else $error("search compared a dead entry");

  // A new result is only loaded from the completion state
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result loaded outside completion");
`endif

endmodule

[bench/deque_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the deque, predicts each result and compares it
module deque_checker
  import bdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [OpW-1:0]          opcode_i,
  input  logic signed [DataW-1:0] value_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [StatW-1:0]        status_i,
  input  logic                    found_i,
  input  logic [PosW-1:0]         position_i,
  input  logic signed [DataW-1:0] popped_value_i,
  input  logic [TotW-1:0]         entry_total_i,
  input  logic signed [DataW-1:0] element_sum_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic [StatW-1:0] status;
    logic             found;
    logic [PosW-1:0]  position;
    logic [DataW-1:0] popped;
    logic [TotW-1:0]  total;
    logic [DataW-1:0] sum;
  } deque_result_t;

  // Shadow copy of the deque
  logic [DataW-1:0] ring_words [DEPTH];
  int unsigned      head_slot;
  int unsigned      live_count;
  logic [DataW-1:0] live_sum;

  deque_result_t    expected_results [$];
  deque_result_t    oldest;
  int               mismatch_count = 0;

  // One line per mismatch, and count it
  task automatic flag_mismatch(input string field, input logic [DataW-1:0] got,
                               input logic [DataW-1:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // Applies one operation to the shadow deque and returns its result
  function automatic deque_result_t apply_deque_op(input logic [OpW-1:0] op,
                                                    input logic [DataW-1:0] val);
    deque_result_t res;
    int unsigned   idx;
    int unsigned   slot;
    res = '0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (live_count >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          if (op == OP_PUSH_FRONT) begin
            head_slot = (head_slot + DEPTH - 1) % DEPTH;
            ring_words[head_slot] = val;
          end else begin
            ring_words[(head_slot + live_count) % DEPTH] = val;
          end
          live_count++;
          live_sum = live_sum + val;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (live_count == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          if (op == OP_POP_FRONT) begin
            res.popped = ring_words[head_slot];
            head_slot = (head_slot + 1) % DEPTH;
          end else begin
            res.popped = ring_words[(head_slot + live_count - 1) % DEPTH];
          end
          live_count--;
          live_sum = live_sum - res.popped;
        end
      end
      OP_SEARCH: begin
        // Walk from the front, first match wins
        for (idx = 0; idx < live_count; idx++) begin
          slot = (head_slot + idx) % DEPTH;
          if (!res.found && ring_words[slot] == val) begin
            res.found    = 1'b1;
            res.position = PosW'(idx + 1);
          end
        end
      end
      default: ;
    endcase
    res.total = TotW'(live_count);
    res.sum   = live_sum;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_slot  = 0;
      live_count = 0;
      live_sum   = '0;
      expected_results.delete();
    end else begin
      // Result transaction: compare against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("result with nothing expected", element_sum_i, '0);
        end else begin
          oldest = expected_results.pop_front();
          if (status_i !== oldest.status)
            flag_mismatch("status", DataW'(status_i), DataW'(oldest.status));
          if (found_i !== oldest.found)
            flag_mismatch("found", DataW'(found_i), DataW'(oldest.found));
          if (position_i !== oldest.position)
            flag_mismatch("position", DataW'(position_i), DataW'(oldest.position));
          if (popped_value_i !== oldest.popped)
            flag_mismatch("popped_value", popped_value_i, oldest.popped);
          if (entry_total_i !== oldest.total)
            flag_mismatch("entry_total", DataW'(entry_total_i), DataW'(oldest.total));
          if (element_sum_i !== oldest.sum)
            flag_mismatch("element_sum", element_sum_i, oldest.sum);
        end
      end
      // Input transaction: predict after the compare so it can't match itself
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(apply_deque_op(opcode_i, value_i));
    end
    fail_count_o <= mismatch_count;
    pending_o    <= expected_results.size();
  end

endmodule

[bench/tb_bounded_deque_with_search.sv]
`timescale 1ns / 100ps

module tb_bounded_deque_with_search;
  import bdq_pkg::*;

  localparam int unsigned DEPTH        = 16;
  localparam int unsigned RANDOM_ITEMS = 600;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // Opcodes the block has no meaning for
  localparam logic [OpW-1:0] OP_RSVD_LO = 3'd5;
  localparam logic [OpW-1:0] OP_RSVD_HI = 3'd7;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic [OpW-1:0]          opcode_i    = OP_SEARCH;
  logic signed [DataW-1:0] value_i     = '0;
  logic                    out_stall_i = 1'b0;
  logic                    in_stall_o;
  logic                    out_valid_o;
  logic [StatW-1:0]        status_o;
  logic                    found_o;
  logic [PosW-1:0]         position_o;
  logic signed [DataW-1:0] popped_value_o;
  logic [TotW-1:0]         entry_total_o;
  logic signed [DataW-1:0] element_sum_o;

  int                      fail_count;
  int                      results_outstanding;
  idle_mode_e              idle_mode     = IDLE_NONE;
  logic                    pressure_go   = 1'b0;
  logic                    pressure_done = 1'b0;
  int unsigned             hold_left     = 0;
  int unsigned             cycle_count   = 0;

  // Recently pushed numbers, used as likely search hits
  logic [DataW-1:0]        recent_pushes [16];
  int unsigned             recent_wr = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  bounded_deque_with_search #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .found_o       (found_o),
    .position_o    (position_o),
    .popped_value_o(popped_value_o),
    .entry_total_o (entry_total_o),
    .element_sum_o (element_sum_o)
  );

  deque_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_i    (in_stall_o),
    .opcode_i      (opcode_i),
    .value_i       (value_i),
    .out_valid_i   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_i      (status_o),
    .found_i       (found_o),
    .position_i    (position_o),
    .popped_value_i(popped_value_o),
    .entry_total_i (entry_total_o),
    .element_sum_i (element_sum_o),
    .fail_count_o  (fail_count),
    .pending_o     (results_outstanding)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: one long hold-off on request, else random stalls per mode
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i   <= 1'b0;
      hold_left     <= 0;
      pressure_done <= 1'b0;
    end else if (pressure_go && !pressure_done) begin
      out_stall_i   <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      pressure_done <= 1'b1;
    end else if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else begin
      case (idle_mode)
        IDLE_RECEIVER: out_stall_i <= ($urandom_range(99) < 68);
        IDLE_BOTH:     out_stall_i <= ($urandom_range(99) < 10);
        default:       out_stall_i <= 1'b0;
      endcase
    end
  end

  // Offers one transaction and returns right after the edge that takes it
  task automatic send_op(input logic [OpW-1:0] op, input logic [DataW-1:0] val);
    int unsigned gap_pct;
    gap_pct = (idle_mode == IDLE_SENDER) ? 68 : (idle_mode == IDLE_BOTH) ? 10 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_i    <= val;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_push(input logic [OpW-1:0] op, input logic [DataW-1:0] val);
    recent_pushes[4'(recent_wr % 16)] = val;
    recent_wr++;
    send_op(op, val);
  endtask

  initial begin
    logic [DataW-1:0] front_vals [8];
    logic [DataW-1:0] num;
    int unsigned      issued;
    int unsigned      push_pct;
    int unsigned      pick;
    int unsigned      k;
    logic [OpW-1:0]   rsvd;

    front_vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
                   32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678};
    for (k = 0; k < 16; k++) recent_pushes[4'(k)] = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty pops and search, reserved opcodes
    send_op(OP_POP_FRONT, 32'hFFFF_FFFF);
    send_op(OP_POP_BACK, '0);
    send_op(OP_SEARCH, '0);
    for (rsvd = OP_RSVD_LO; rsvd != OP_RSVD_HI; rsvd++) send_op(rsvd, $urandom);
    send_op(OP_RSVD_HI, $urandom);
    // Fill from both ends with extreme numbers, sum wraps on the way
    for (k = 0; k < 8; k++) send_push(OP_PUSH_FRONT, front_vals[3'(k)]);
    for (k = 0; k < 8; k++) send_push(OP_PUSH_BACK, 32'h3C3C_0000 + k);
    // Full deque rejects both push flavors
    send_op(OP_PUSH_FRONT, 32'h0BAD_0001);
    send_op(OP_PUSH_BACK, 32'h0BAD_0002);
    // Hit at the last position, and a miss on a full deque
    send_op(OP_SEARCH, 32'h3C3C_0007);
    send_op(OP_SEARCH, 32'h0BAD_0001);

    // Random part, one idle mode per quarter
    issued = 0;
    push_pct = 50;
    for (int phase = 0; phase < 4; phase++) begin
      idle_mode = idle_mode_e'(phase);
      if (phase == 0) pressure_go = 1'b1;
      while (issued < (phase + 1) * RANDOM_ITEMS / 4) begin
        // Shift the push bias now and then so the deque swings full and empty
        if (issued % 40 == 0) begin
          case ($urandom_range(2))
            0:       push_pct = 15;
            1:       push_pct = 50;
            default: push_pct = 85;
          endcase
        end
        pick = $urandom_range(99);
        if (pick < 4) begin
          // Noise: reserved opcode
          send_op(OpW'(OP_RSVD_HI - $urandom_range(2)), $urandom);
        end else begin
          num = ($urandom_range(99) < 30) ? DataW'($urandom_range(7)) : DataW'($urandom);
          if ($urandom_range(99) < push_pct) begin
            send_push($urandom_range(1) ? OP_PUSH_BACK : OP_PUSH_FRONT, num);
          end else if ($urandom_range(99) < 65) begin
            send_op($urandom_range(1) ? OP_POP_BACK : OP_POP_FRONT, num);
          end else begin
            if ($urandom_range(99) < 70) num = recent_pushes[4'($urandom_range(15))];
            send_op(OP_SEARCH, num);
          end
          issued++;
        end
      end
    end
    in_valid_i <= 1'b0;

    // Drain, then give any stray result a chance to show up
    @(posedge clk_i);
    while (results_outstanding != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
